/* rtl/ssa_pkg.sv */
// Shared types and constants for the swap slot allocator.
// No dependencies; every other file of the block refers to it by scoped names.
package ssa_pkg;

  localparam int SLOTS            = 1024;
  localparam int SECTORS_PER_SLOT = 8;

  // field widths of the channel words
  localparam int SLOT_W = 10;
  localparam int SECT_W = 13;
  localparam int CFG_W  = 11;

  // used-slot bitmap kept as words of WORD_W bits
  localparam int WORD_W = 32;
  localparam int WB     = $clog2(WORD_W);
  localparam int WORDS  = SLOTS / WORD_W;
  localparam int AW     = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int LIM_W  = $clog2(SLOTS + 1);
  localparam int LHI_W  = LIM_W - WB;
  localparam int OFF_W  = (SECTORS_PER_SLOT > 1) ? $clog2(SECTORS_PER_SLOT) : 1;

  localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_FULL   = 2'd1,
    ST_UNUSED = 2'd2,
    ST_RANGE  = 2'd3
  } status_t;

  typedef enum logic {
    FUNC_ALLOC   = 1'b0,
    FUNC_RELEASE = 1'b1
  } func_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_REL_CHK,
    S_EMIT
  } state_t;

  // one read and one write port on the map memory
  typedef struct packed {
    logic              rd_en;
    logic [AW-1:0]     rd_addr;
    logic              wr_en;
    logic [AW-1:0]     wr_addr;
    logic [WORD_W-1:0] wr_data;
  } ram_req_t;

endpackage

/* rtl/ssa_in_if.sv */
// Request channel of the swap slot allocator: valid/ready plus func and slot.
// Depends on ssa_pkg for field widths.
interface ssa_in_if;
  logic                        valid;
  logic                        ready;
  logic                        func;
  logic [ssa_pkg::SLOT_W-1:0]  slot;

  modport source (output valid, func, slot, input ready);
  modport sink   (input valid, func, slot, output ready);
endinterface

/* rtl/ssa_out_if.sv */
// Result channel of the swap slot allocator: valid/ready plus one result word.
// Depends on ssa_pkg for field widths.
interface ssa_out_if;
  logic                        valid;
  logic                        ready;
  logic [1:0]                  status;
  logic [ssa_pkg::SLOT_W-1:0]  slot_index;
  logic [ssa_pkg::SECT_W-1:0]  sector_address;
  logic                        last;

  modport source (output valid, status, slot_index, sector_address, last, input ready);
  modport sink   (input valid, status, slot_index, sector_address, last, output ready);
endinterface

/* rtl/ssa_cfg_if.sv */
// Configuration write channel: valid/ready plus the slot_count write data.
// Depends on ssa_pkg for the register width.
interface ssa_cfg_if;
  logic                       valid;
  logic                       ready;
  logic [ssa_pkg::CFG_W-1:0]  data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

/* rtl/ssa_map_ram.sv */
// Used-slot bitmap memory: WORDS x WORD_W, one write and one read port, registered read.
// Per-word valid bits stand in for the reset image. Depends on ssa_pkg.
module ssa_map_ram (
  input  logic                            clk,
  input  logic                            rst_n,
  input  ssa_pkg::ram_req_t               req,
  output logic [ssa_pkg::WORD_W-1:0]      rd_word
);

  logic [ssa_pkg::WORD_W-1:0] mem [ssa_pkg::WORDS];
  logic [ssa_pkg::WORDS-1:0]  vld_r;
  logic [ssa_pkg::WORD_W-1:0] rd_data_r;
  logic                       rd_vld_r;
  logic [ssa_pkg::AW-1:0]     rd_addr_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
    if (req.rd_en) begin
      rd_data_r <= mem[req.rd_addr];
      rd_addr_r <= req.rd_addr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r    <= '0;
      rd_vld_r <= 1'b0;
    end else begin
      if (req.wr_en) begin
        vld_r[req.wr_addr] <= 1'b1;
      end
      if (req.rd_en) begin
        rd_vld_r <= vld_r[req.rd_addr];
      end
    end
  end

  // unwritten word reads as reset image: slot 0 used, rest free
  assign rd_word = rd_vld_r ? rd_data_r :
                   (rd_addr_r == '0) ? ssa_pkg::WORD_W'(1) : '0;

endmodule

/* rtl/ssa_ctrl.sv */
// Allocator sequencer: word-by-word first-fit scan, release check, result emission.
// Drives the map memory ports; depends on ssa_pkg and the channel interfaces.
module ssa_ctrl (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic [ssa_pkg::LIM_W-1:0]        lim,
  ssa_in_if.sink                           in_ch,
  ssa_out_if.source                        out_ch,
  output ssa_pkg::ram_req_t                ram_req,
  input  logic [ssa_pkg::WORD_W-1:0]       rd_word
);

  ssa_pkg::state_t                state_r, state_nxt;
  logic [ssa_pkg::SLOT_W-1:0]     slot_r, slot_nxt;
  logic [ssa_pkg::AW-1:0]         scan_addr_r, scan_addr_nxt;
  logic                           out_valid_r, out_valid_nxt;
  ssa_pkg::status_t               status_r, status_nxt;
  logic [ssa_pkg::SLOT_W-1:0]     slot_idx_r, slot_idx_nxt;
  logic [ssa_pkg::SECT_W-1:0]     sector_r, sector_nxt;
  logic                           last_r, last_nxt;
  logic [ssa_pkg::OFF_W-1:0]      off_r, off_nxt;

  logic                           in_acc;
  logic                           out_acc;
  logic                           rel_bad;
  logic [ssa_pkg::LHI_W-1:0]      lim_hi;
  logic [ssa_pkg::WB-1:0]         lim_lo;
  logic [ssa_pkg::LIM_W-1:0]      lim_m1;
  logic [ssa_pkg::AW-1:0]         last_word;
  logic [ssa_pkg::WORD_W-1:0]     range_mask;
  logic [ssa_pkg::WORD_W-1:0]     avail;
  logic                           found;
  logic [ssa_pkg::WB-1:0]         pos;
  logic [ssa_pkg::SLOT_W-1:0]     found_slot;
  logic                           rel_bit;
  logic                           at_last_word;

  assign in_acc  = in_ch.valid && in_ch.ready;
  assign out_acc = out_valid_r && out_ch.ready;

  assign lim_hi = lim[ssa_pkg::LIM_W-1:ssa_pkg::WB];
  assign lim_lo = lim[ssa_pkg::WB-1:0];
  assign lim_m1 = lim - ssa_pkg::LIM_W'(1);
  assign last_word = (lim == '0) ? '0 : lim_m1[ssa_pkg::WB+ssa_pkg::AW-1:ssa_pkg::WB];
  assign at_last_word = (scan_addr_r == last_word);

  assign rel_bad = (in_ch.slot == '0) ||
                   (ssa_pkg::LIM_W'(in_ch.slot) >= lim);

  // bits of the current word that lie below the active limit
  always_comb begin
    if (ssa_pkg::LHI_W'(scan_addr_r) < lim_hi) begin
      range_mask = '1;
    end else if (ssa_pkg::LHI_W'(scan_addr_r) == lim_hi) begin
      range_mask = (ssa_pkg::WORD_W'(1) << lim_lo) - ssa_pkg::WORD_W'(1);
    end else begin
      range_mask = '0;
    end
  end

  assign avail = ~rd_word & range_mask;
  assign found = |avail;

  // lowest free bit
  always_comb begin
    pos = '0;
    for (int i = ssa_pkg::WORD_W - 1; i >= 0; i--) begin
      if (avail[i]) begin
        pos = ssa_pkg::WB'(i);
      end
    end
  end

  assign found_slot = ssa_pkg::SLOT_W'({scan_addr_r, pos});
  assign rel_bit    = rd_word[slot_r[ssa_pkg::WB-1:0]];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ssa_pkg::S_IDLE: begin
        if (in_acc) begin
          if (in_ch.func == ssa_pkg::FUNC_RELEASE) begin
            state_nxt = rel_bad ? ssa_pkg::S_EMIT : ssa_pkg::S_REL_CHK;
          end else begin
            state_nxt = ssa_pkg::S_SCAN;
          end
        end
      end
      ssa_pkg::S_SCAN: begin
        if (found || at_last_word) begin
          state_nxt = ssa_pkg::S_EMIT;
        end
      end
      ssa_pkg::S_REL_CHK: begin
        state_nxt = ssa_pkg::S_EMIT;
      end
      ssa_pkg::S_EMIT: begin
        if (out_acc && last_r) begin
          state_nxt = ssa_pkg::S_IDLE;
        end
      end
      default: state_nxt = ssa_pkg::S_IDLE;
    endcase
  end

  // outputs and datapath
  always_comb begin
    in_ch.ready   = 1'b0;
    ram_req       = '0;
    slot_nxt      = slot_r;
    scan_addr_nxt = scan_addr_r;
    out_valid_nxt = out_valid_r;
    status_nxt    = status_r;
    slot_idx_nxt  = slot_idx_r;
    sector_nxt    = sector_r;
    last_nxt      = last_r;
    off_nxt       = off_r;
    case (state_r)
      ssa_pkg::S_IDLE: begin
        in_ch.ready = 1'b1;
        if (in_acc) begin
          slot_nxt = in_ch.slot;
          if (in_ch.func == ssa_pkg::FUNC_RELEASE) begin
            if (rel_bad) begin
              out_valid_nxt = 1'b1;
              status_nxt    = ssa_pkg::ST_RANGE;
              slot_idx_nxt  = '0;
              sector_nxt    = '0;
              last_nxt      = 1'b1;
            end else begin
              ram_req.rd_en   = 1'b1;
              ram_req.rd_addr = ssa_pkg::AW'(in_ch.slot >> ssa_pkg::WB);
            end
          end else begin
            ram_req.rd_en   = 1'b1;
            ram_req.rd_addr = '0;
            scan_addr_nxt   = '0;
          end
        end
      end
      ssa_pkg::S_SCAN: begin
        if (found) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = scan_addr_r;
          ram_req.wr_data = rd_word | (ssa_pkg::WORD_W'(1) << pos);
          out_valid_nxt   = 1'b1;
          status_nxt      = ssa_pkg::ST_OK;
          slot_idx_nxt    = found_slot;
          sector_nxt      = ssa_pkg::SECT_W'(found_slot) *
                            ssa_pkg::SECT_W'(ssa_pkg::SECTORS_PER_SLOT);
          off_nxt         = '0;
          last_nxt        = (ssa_pkg::SECTORS_PER_SLOT == 1);
        end else if (at_last_word) begin
          out_valid_nxt = 1'b1;
          status_nxt    = ssa_pkg::ST_FULL;
          slot_idx_nxt  = '0;
          sector_nxt    = '0;
          last_nxt      = 1'b1;
        end else begin
          ram_req.rd_en   = 1'b1;
          ram_req.rd_addr = scan_addr_r + ssa_pkg::AW'(1);
          scan_addr_nxt   = scan_addr_r + ssa_pkg::AW'(1);
        end
      end
      ssa_pkg::S_REL_CHK: begin
        out_valid_nxt = 1'b1;
        if (rel_bit) begin
          ram_req.wr_en   = 1'b1;
          ram_req.wr_addr = ssa_pkg::AW'(slot_r >> ssa_pkg::WB);
          ram_req.wr_data = rd_word & ~(ssa_pkg::WORD_W'(1) << slot_r[ssa_pkg::WB-1:0]);
          status_nxt      = ssa_pkg::ST_OK;
          slot_idx_nxt    = slot_r;
          sector_nxt      = ssa_pkg::SECT_W'(slot_r) *
                            ssa_pkg::SECT_W'(ssa_pkg::SECTORS_PER_SLOT);
          off_nxt         = '0;
          last_nxt        = (ssa_pkg::SECTORS_PER_SLOT == 1);
        end else begin
          status_nxt   = ssa_pkg::ST_UNUSED;
          slot_idx_nxt = '0;
          sector_nxt   = '0;
          last_nxt     = 1'b1;
        end
      end
      ssa_pkg::S_EMIT: begin
        if (out_acc) begin
          if (last_r) begin
            out_valid_nxt = 1'b0;
          end else begin
            off_nxt    = off_r + ssa_pkg::OFF_W'(1);
            sector_nxt = sector_r + ssa_pkg::SECT_W'(1);
            last_nxt   = (off_r + ssa_pkg::OFF_W'(1) ==
                          ssa_pkg::OFF_W'(ssa_pkg::SECTORS_PER_SLOT - 1));
          end
        end
      end
      default: begin
        out_valid_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ssa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    slot_r      <= slot_nxt;
    scan_addr_r <= scan_addr_nxt;
    status_r    <= status_nxt;
    slot_idx_r  <= slot_idx_nxt;
    sector_r    <= sector_nxt;
    last_r      <= last_nxt;
    off_r       <= off_nxt;
  end

  assign out_ch.valid          = out_valid_r;
  assign out_ch.status         = status_r;
  assign out_ch.slot_index     = slot_idx_r;
  assign out_ch.sector_address = sector_r;
  assign out_ch.last           = last_r;

endmodule

/* rtl/swap_slot_allocator.sv */
// Top level of the swap slot allocator: slot_count register, map memory, sequencer.
// Depends on ssa_pkg, the channel interfaces, ssa_map_ram and ssa_ctrl.
//
// Usage:
//   in_ch  : request word {func, slot}; func 0 allocates the lowest free slot,
//            func 1 releases the given slot.
//   out_ch : result words {status, slot_index, sector_address, last}. A good
//            item yields SECTORS_PER_SLOT words with consecutive sectors, last
//            on the final one; a failed item yields one word with last set.
//   cfg_ch : slot_count write, always ready; values above SLOTS saturate.
// One item is handled at a time; in_ch.ready is high only while idle.
// Allocate: one map word (32 slots) is checked per cycle, starting at word 0,
//   until a free slot below the limit is found or the last word in range has
//   been checked; the result is registered from the word where the scan stops.
// Release: the map word is read at accept and checked in the S_REL_CHK state,
//   which registers the result; range errors show in the cycle right after accept.
// Results then stream one per cycle; a stalled receiver holds the output
//   register and the sequencer simply waits.
// Reset: per-word valid bits make the map read as slot 0 used, all others
//   free, so the block is ready as soon as reset is released.
module swap_slot_allocator (
  input  logic       clk,
  input  logic       rst_n,
  ssa_in_if.sink     in_ch,
  ssa_out_if.source  out_ch,
  ssa_cfg_if.sink    cfg_ch
);

  logic [ssa_pkg::CFG_W-1:0]   slot_count_r;
  logic [ssa_pkg::LIM_W-1:0]   lim;
  ssa_pkg::ram_req_t           ram_req;
  logic [ssa_pkg::WORD_W-1:0]  rd_word;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_count_r <= ssa_pkg::CFG_RESET;
    end else if (cfg_ch.valid && cfg_ch.ready) begin
      slot_count_r <= cfg_ch.data;
    end
  end

  assign lim = (slot_count_r > ssa_pkg::CFG_W'(ssa_pkg::SLOTS)) ?
               ssa_pkg::LIM_W'(ssa_pkg::SLOTS) : ssa_pkg::LIM_W'(slot_count_r);

  ssa_map_ram u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (ram_req),
    .rd_word (rd_word)
  );

  ssa_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .lim     (lim),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .ram_req (ram_req),
    .rd_word (rd_word)
  );

endmodule

/* rtl/ssa_checker.sv */
// Port-level checks for swap_slot_allocator, attached with the bind below.
// Depends on ssa_pkg for widths and status codes.
module ssa_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [1:0]                  out_status,
  input logic [ssa_pkg::SLOT_W-1:0]  out_slot_index,
  input logic [ssa_pkg::SECT_W-1:0]  out_sector_address,
  input logic                        out_last
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sector_address) && $stable(out_last))
    else $error("result word changed while stalled");

  a_err_word: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != ssa_pkg::ST_OK) |->
      out_last && (out_slot_index == '0) && (out_sector_address == '0))
    else $error("error word not a single zeroed word");

  a_no_slot0: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == ssa_pkg::ST_OK) |-> (out_slot_index != '0))
    else $error("reserved slot handed out or released");

  a_run_step: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ready && !out_last |=>
      out_valid && (out_sector_address == $past(out_sector_address) + 1'b1) &&
      $stable(out_slot_index))
    else $error("sector run not consecutive");

  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |-> !out_valid)
    else $error("request taken while results pending");

endmodule

bind swap_slot_allocator ssa_checker u_ssa_checker (
  .clk                (clk),
  .rst_n              (rst_n),
  .in_valid           (in_ch.valid),
  .in_ready           (in_ch.ready),
  .out_valid          (out_ch.valid),
  .out_ready          (out_ch.ready),
  .out_status         (out_ch.status),
  .out_slot_index     (out_ch.slot_index),
  .out_sector_address (out_ch.sector_address),
  .out_last           (out_ch.last)
);

/* tb/tb.sv */
// Self-checking testbench for swap_slot_allocator: requests, result words, slot_count writes.
// Depends on ssa_pkg, the ssa_in_if, ssa_out_if and ssa_cfg_if interfaces, and the block.
// Expected words are predicted at request accept and checked in order at the result port.
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    ssa_pkg::func_t             func;
    logic [ssa_pkg::SLOT_W-1:0] slot;
  } request_t;

  typedef struct packed {
    ssa_pkg::status_t           status;
    logic [ssa_pkg::SLOT_W-1:0] slot_index;
    logic [ssa_pkg::SECT_W-1:0] sector;
    logic                       last;
  } sector_word_t;

  logic clk;
  logic rst_n;

  ssa_in_if  in_ch ();
  ssa_out_if out_ch ();
  ssa_cfg_if cfg_ch ();

  swap_slot_allocator uut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg_ch (cfg_ch)
  );

  request_t                   pending_requests[$];
  sector_word_t               expected_words[$];
  bit [ssa_pkg::SLOTS-1:0]    used_slots;
  logic [ssa_pkg::CFG_W-1:0]  slot_count_q;
  int                         send_idle_pct = 17;
  int                         recv_idle_pct = 57;
  bit                         hold_send = 1'b0;
  int                         mismatch_count = 0;
  int                         cycle_count = 0;

  function automatic int active_limit();
    return (slot_count_q > ssa_pkg::SLOTS) ? ssa_pkg::SLOTS : int'(slot_count_q);
  endfunction

  // first-fit allocate or checked release; pushes the sector run or one error word
  function automatic void predict_request(input ssa_pkg::func_t f,
                                          input logic [ssa_pkg::SLOT_W-1:0] s);
    int               lim;
    int               run_slot;
    ssa_pkg::status_t err;
    sector_word_t     w;
    lim      = active_limit();
    run_slot = -1;
    err      = ssa_pkg::ST_OK;
    if (f == ssa_pkg::FUNC_ALLOC) begin
      for (int i = 0; i < lim && run_slot < 0; i++) begin
        if (!used_slots[i]) run_slot = i;
      end
      if (run_slot < 0) err = ssa_pkg::ST_FULL;
      else used_slots[run_slot] = 1'b1;
    end else if (s == 0 || s >= lim) begin
      err = ssa_pkg::ST_RANGE;
    end else if (!used_slots[s]) begin
      err = ssa_pkg::ST_UNUSED;
    end else begin
      run_slot = s;
      used_slots[s] = 1'b0;
    end
    if (run_slot < 0) begin
      w = '{status: err, slot_index: '0, sector: '0, last: 1'b1};
      expected_words.push_back(w);
    end else begin
      for (int k = 0; k < ssa_pkg::SECTORS_PER_SLOT; k++) begin
        w.status     = ssa_pkg::ST_OK;
        w.slot_index = ssa_pkg::SLOT_W'(run_slot);
        w.sector     = ssa_pkg::SECT_W'(run_slot * ssa_pkg::SECTORS_PER_SLOT + k);
        w.last       = (k == ssa_pkg::SECTORS_PER_SLOT - 1);
        expected_words.push_back(w);
      end
    end
  endfunction

  // mostly a slot that is in use and in range; sometimes edges and noise
  function automatic logic [ssa_pkg::SLOT_W-1:0] pick_release_slot();
    int lim;
    int start;
    int idx;
    lim = active_limit();
    case ($urandom_range(9))
      0: return '0;
      1: return ssa_pkg::SLOT_W'((lim < ssa_pkg::SLOTS) ? lim : ssa_pkg::SLOTS - 1);
      2: return ssa_pkg::SLOT_W'($urandom_range(ssa_pkg::SLOTS - 1));
      default: begin
        if (lim >= 2) begin
          start = $urandom_range(1, lim - 1);
          for (int k = 0; k < lim - 1; k++) begin
            idx = 1 + (start - 1 + k) % (lim - 1);
            if (used_slots[idx]) return ssa_pkg::SLOT_W'(idx);
          end
        end
        return ssa_pkg::SLOT_W'($urandom_range(ssa_pkg::SLOTS - 1));
      end
    endcase
  endfunction

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // request driver; also tracks slot_count writes and predicts on accept
  always @(posedge clk) begin : drive_requests
    request_t next_req;
    if (!rst_n) begin
      in_ch.valid  <= 1'b0;
      used_slots   = '0;
      used_slots[0] = 1'b1;
      slot_count_q = ssa_pkg::CFG_RESET;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) slot_count_q = cfg_ch.data;
      if (in_ch.valid && in_ch.ready)
        predict_request(ssa_pkg::func_t'(in_ch.func), in_ch.slot);
      if (!in_ch.valid || in_ch.ready) begin
        if (pending_requests.size() > 0 && !hold_send &&
            $urandom_range(99) >= send_idle_pct) begin
          next_req = pending_requests.pop_front();
          in_ch.valid <= 1'b1;
          in_ch.func  <= next_req.func;
          in_ch.slot  <= next_req.slot;
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : check_results
    sector_word_t exp_w;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      out_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      if (out_ch.valid && out_ch.ready) begin
        if (expected_words.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected word: status %0d slot %0d sector %0d last %0d",
                     out_ch.status, out_ch.slot_index, out_ch.sector_address, out_ch.last);
        end else begin
          exp_w = expected_words.pop_front();
          if (out_ch.status !== exp_w.status || out_ch.slot_index !== exp_w.slot_index ||
              out_ch.sector_address !== exp_w.sector || out_ch.last !== exp_w.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("word mismatch: exp %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
                       exp_w.status, exp_w.slot_index, exp_w.sector, exp_w.last,
                       out_ch.status, out_ch.slot_index, out_ch.sector_address,
                       out_ch.last);
          end
        end
      end
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** swap_slot_allocator: FAILED **");
      $finish;
    end
  end

  // keep the driver queue short so release picks follow the current map
  task automatic queue_request(input ssa_pkg::func_t f,
                               input logic [ssa_pkg::SLOT_W-1:0] s);
    request_t req;
    while (pending_requests.size() > 1) @(posedge clk);
    req.func = f;
    req.slot = s;
    pending_requests.push_back(req);
  endtask

  // sampled mid-cycle so the driver's updates at the edge have settled
  task automatic wait_until_idle();
    while (pending_requests.size() > 0 || in_ch.valid || expected_words.size() > 0 ||
           !in_ch.ready)
      @(negedge clk);
  endtask

  task automatic write_slot_count(input int value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= ssa_pkg::CFG_W'(value);
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic run_phase(input int cfg_value, input int n, input int alloc_pct,
                           input int send_pct, input int recv_pct, input bit pause_midway);
    wait_until_idle();
    write_slot_count(cfg_value);
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    for (int k = 0; k < n; k++) begin
      if ($urandom_range(99) < alloc_pct)
        queue_request(ssa_pkg::FUNC_ALLOC,
                      ssa_pkg::SLOT_W'($urandom_range(ssa_pkg::SLOTS - 1)));
      else
        queue_request(ssa_pkg::FUNC_RELEASE, pick_release_slot());
      // sender holds a queued word until the block has drained
      if (pause_midway && k == n / 2) begin
        hold_send = 1'b1;
        while (in_ch.valid || expected_words.size() > 0) @(negedge clk);
        hold_send = 1'b0;
      end
    end
  endtask

  initial begin : stimulus
    rst_n        = 1'b0;
    cfg_ch.valid = 1'b0;
    cfg_ch.data  = '0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // reset limit: reserved slot, unused slots, first fit after frees
    queue_request(ssa_pkg::FUNC_RELEASE, '0);
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(1023));
    queue_request(ssa_pkg::FUNC_ALLOC, '0);
    queue_request(ssa_pkg::FUNC_ALLOC, ssa_pkg::SLOT_W'(1023));
    queue_request(ssa_pkg::FUNC_ALLOC, '0);
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(2));
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(2));
    queue_request(ssa_pkg::FUNC_ALLOC, '0);
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(1));
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(3));
    queue_request(ssa_pkg::FUNC_ALLOC, '0);
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(512));
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(1));
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(2));

    // one usable slot: full map, release at the limit
    wait_until_idle();
    write_slot_count(2);
    queue_request(ssa_pkg::FUNC_ALLOC, '0);
    queue_request(ssa_pkg::FUNC_ALLOC, '0);
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(2));
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(1));
    queue_request(ssa_pkg::FUNC_ALLOC, '0);

    // no usable slot at all; slot 1 stays used but out of range
    wait_until_idle();
    write_slot_count(0);
    queue_request(ssa_pkg::FUNC_ALLOC, '0);
    queue_request(ssa_pkg::FUNC_RELEASE, '0);
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(1));
    wait_until_idle();
    write_slot_count(1);
    queue_request(ssa_pkg::FUNC_ALLOC, ssa_pkg::SLOT_W'(1023));
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(1));

    // saturating limit brings slot 1 back into range
    wait_until_idle();
    write_slot_count(2047);
    queue_request(ssa_pkg::FUNC_RELEASE, ssa_pkg::SLOT_W'(1));

    run_phase(2047, 110, 70, 17, 57, 1'b0);
    run_phase(40, 60, 55, 57, 17, 1'b0);
    run_phase(1024, 100, 50, 57, 17, 1'b1);
    run_phase($urandom_range(3, 1023), 90, 55, 0, 0, 1'b0);

    wait_until_idle();
    repeat (40) @(posedge clk);
    if (mismatch_count == 0 && expected_words.size() == 0) begin
      $display("** swap_slot_allocator: PASSED **");
    end else begin
      $display("** swap_slot_allocator: FAILED **");
    end
    $finish;
  end

endmodule

/* sim.f */
rtl/ssa_pkg.sv
rtl/ssa_in_if.sv
rtl/ssa_out_if.sv
rtl/ssa_cfg_if.sv
rtl/ssa_map_ram.sv
rtl/ssa_ctrl.sv
rtl/swap_slot_allocator.sv
rtl/ssa_checker.sv
tb/tb.sv
